// ----- design/tpfa_pkg.sv -----
// Shared constants and types for the two-tier page frame allocator.
package tpfa_pkg;
  localparam int MainFrames = 1024;
  localparam int VirtFrames = 1024;
  localparam int MAW = $clog2(MainFrames);
  localparam int VAW = $clog2(VirtFrames);
  localparam int FW = 10;

  typedef enum logic [1:0] {ACT_LOAD = 2'd0, ACT_KILL = 2'd1, ACT_XLATE = 2'd2,
                            ACT_NONE = 2'd3} action_t;
  typedef enum logic [1:0] {ST_MAIN = 2'd0, ST_VIRT = 2'd1, ST_FULL = 2'd2,
                            ST_BAD = 2'd3} status_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [10:0] size_kb;
    logic [15:0] process_id;
    logic [9:0]  page_number;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] assigned_id;
    logic [9:0]  frame;
  } rsp_t;

  // One entry of a frame table: owner ID (0 is free) and logical page.
  typedef struct packed {
    logic [15:0] owner;
    logic [9:0]  page;
  } entry_t;
endpackage

// ----- design/tpfa_if.sv -----
// Valid/ready channel interfaces for requests and results.
interface tpfa_req_if;
  import tpfa_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tpfa_rsp_if;
  import tpfa_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/tpfa_table.sv -----
// Frame table memory: one write port and one registered read port.
module tpfa_table
  import tpfa_pkg::*;
#(
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  entry_t                   wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output entry_t                   rdata
);
  entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/two_tier_page_frame_allocator.sv -----
// Two-tier page frame allocator: a sequencer that sweeps two frame tables.
//
// A request that needs a sweep reads a frame table one entry per cycle
// through a synchronous memory read port: a kill sweeps the main table then
// the virtual table fully; a load sweeps only the pool it fills, stopping
// once enough frames are taken; a translate sweeps the main table then the
// virtual table and stops at its first hit. After reset a clearing pass
// writes every entry of both tables to zero, during which no request is
// taken. The result is held in an output register, and no new request is
// taken until that result has been accepted.
module two_tier_page_frame_allocator
  import tpfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  tpfa_req_if.sink    in_req,
  tpfa_rsp_if.source  out_rsp
);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_WAIT} state_t;

  state_t      state_r;
  logic [3:0]  psl_r;
  logic [10:0] mfree_r, vfree_r;
  logic [15:0] next_id_r;
  req_t        req_r;
  logic        pool_r;          // 0 main, 1 virtual
  logic [10:0] addr_r;          // read address, counts to the depth
  logic        rvalid_r;        // read data corresponds to last address
  logic [MAW-1:0] raddr_d_r;    // address of the data now on rdata
  logic [10:0] need_r, taken_r, freed_m_r, freed_v_r;
  logic [15:0] id_r;
  logic        out_valid_r;
  rsp_t        out_r;

  entry_t m_rd, v_rd, wdata;
  logic m_we, v_we;
  logic [MAW-1:0] waddr;
  logic [MAW-1:0] raddr;

  assign raddr = addr_r[MAW-1:0];

  tpfa_table #(.Depth(MainFrames)) u_main (
    .clk, .we(m_we), .waddr, .wdata, .raddr, .rdata(m_rd));
  tpfa_table #(.Depth(VirtFrames)) u_virt (
    .clk, .we(v_we), .waddr, .wdata, .raddr(raddr[VAW-1:0]), .rdata(v_rd));

  entry_t rd;
  logic [20:0] pages_w;
  logic [10:0] pages;
  logic [10:0] depth_cur;
  logic hit_free, hit_own, hit_xl;

  assign rd = pool_r ? v_rd : m_rd;
  assign depth_cur = pool_r ? 11'(VirtFrames) : 11'(MainFrames);
  assign pages_w = {in_req.data.size_kb, 10'd0} >> psl_r;
  // Page counts above 1024 never fit a pool; clamp so the compare stays right.
  assign pages = (pages_w > 21'd2047) ? 11'd2047 : pages_w[10:0];
  assign hit_free = rd.owner == 16'd0;
  assign hit_own  = rd.owner == req_r.process_id;
  assign hit_xl   = hit_own && rd.page == req_r.page_number;

  assign in_req.ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data = out_r;

  // Writes happen on the entry whose read data is being examined; the next
  // read is never that same entry, so no forwarding is needed.
  always_comb begin
    m_we = 1'b0;
    v_we = 1'b0;
    waddr = raddr_d_r;
    wdata = '0;
    if (state_r == S_CLEAR) begin
      m_we = 1'b1;
      v_we = 1'b1;
      waddr = raddr;
    end else if (state_r == S_SCAN && rvalid_r) begin
      if (req_r.action == ACT_LOAD && hit_free && taken_r < need_r) begin
        wdata.owner = id_r;
        wdata.page = taken_r[FW-1:0];
        m_we = !pool_r;
        v_we = pool_r;
      end else if (req_r.action == ACT_KILL && hit_own) begin
        m_we = !pool_r;
        v_we = pool_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      psl_r <= '0;
      mfree_r <= 11'(MainFrames);
      vfree_r <= 11'(VirtFrames);
      next_id_r <= 16'd1;
      addr_r <= '0;
      rvalid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) psl_r <= cfg_wdata;
      if (out_rsp.valid && out_rsp.ready) out_valid_r <= 1'b0;
      raddr_d_r <= raddr;
      case (state_r)
        S_CLEAR: begin
          addr_r <= addr_r + 11'd1;
          if (addr_r == 11'(MainFrames - 1)) begin
            addr_r <= '0;
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_req.valid && in_req.ready) begin
            req_r <= in_req.data;
            addr_r <= 11'd1;
            rvalid_r <= 1'b1;
            taken_r <= '0;
            freed_m_r <= '0;
            freed_v_r <= '0;
            id_r <= next_id_r;
            need_r <= pages;
            out_r <= '{status: ST_BAD, assigned_id: 16'd0, frame: '0};
            state_r <= S_SCAN;
            pool_r <= 1'b0;
            case (in_req.data.action)
              ACT_LOAD: begin
                if (next_id_r == 16'd0 ||
                    (mfree_r < pages && vfree_r < pages)) begin
                  out_r.status <= ST_FULL;
                  state_r <= S_WAIT;
                end else begin
                  pool_r <= (mfree_r < pages);
                  out_r.status <= (mfree_r < pages) ? ST_VIRT : ST_MAIN;
                  out_r.assigned_id <= next_id_r;
                  next_id_r <= next_id_r + 16'd1;
                  if (mfree_r < pages) vfree_r <= vfree_r - pages;
                  else mfree_r <= mfree_r - pages;
                  if (pages == 11'd0) state_r <= S_WAIT;
                end
              end
              ACT_KILL, ACT_XLATE: begin
                if (in_req.data.process_id == 16'd0) state_r <= S_WAIT;
              end
              default: state_r <= S_WAIT;
            endcase
            if (state_r == S_IDLE) addr_r <= 11'd1;
          end else begin
            addr_r <= '0;
          end
        end
        S_SCAN: begin
          // rd holds entry raddr_d_r of the current pool.
          addr_r <= addr_r + 11'd1;
          // The first cycle after switching to the virtual table repeats
          // entry 0, so it is skipped here and examined on the next cycle.
          if (rvalid_r) begin
            case (req_r.action)
              ACT_LOAD: begin
                if (hit_free && taken_r < need_r) begin
                  taken_r <= taken_r + 11'd1;
                  if (taken_r + 11'd1 == need_r) state_r <= S_WAIT;
                end
              end
              ACT_KILL: begin
                if (hit_own) begin
                  if (pool_r) freed_v_r <= freed_v_r + 11'd1;
                  else freed_m_r <= freed_m_r + 11'd1;
                end
              end
              ACT_XLATE: begin
                if (hit_xl) begin
                  out_r.status <= pool_r ? ST_VIRT : ST_MAIN;
                  out_r.frame <= raddr_d_r;
                  state_r <= S_WAIT;
                end
              end
              default: state_r <= S_WAIT;
            endcase
          end
          if (addr_r == depth_cur && !(req_r.action == ACT_XLATE && hit_xl) &&
              !(req_r.action == ACT_LOAD && hit_free && taken_r + 11'd1 == need_r)) begin
            if (!pool_r && req_r.action != ACT_LOAD) begin
              pool_r <= 1'b1;
              addr_r <= '0;
              rvalid_r <= 1'b0;
            end else if (rvalid_r) begin
              state_r <= S_WAIT;
            end
          end else begin
            rvalid_r <= 1'b1;
          end
          if (!rvalid_r) rvalid_r <= 1'b1;
        end
        S_WAIT: begin
          if (req_r.action == ACT_KILL && req_r.process_id != 16'd0) begin
            mfree_r <= mfree_r + freed_m_r;
            vfree_r <= vfree_r + freed_v_r;
            out_r.status <= (freed_m_r != 0) ? ST_MAIN :
                            (freed_v_r != 0) ? ST_VIRT : ST_BAD;
          end
          out_valid_r <= 1'b1;
          addr_r <= '0;
          rvalid_r <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  ap_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_req.ready)
    else $error("request taken while busy");
  ap_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (mfree_r <= 11'(MainFrames)) && (vfree_r <= 11'(VirtFrames)))
    else $error("free count beyond pool size");
  ap_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |=> out_valid_r)
    else $error("result lost");
endmodule

// ----- test/tpfa_checker.sv -----
// Checker for the page frame allocator: shadow frame tables and result comparison.
`timescale 1ns / 1ps
module tpfa_checker
  import tpfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  tpfa_req_if         req,
  tpfa_rsp_if         rsp,
  output int          mismatches,
  output int          awaiting
);
  logic [15:0] main_owner [MainFrames];
  logic [9:0]  main_page [MainFrames];
  logic [15:0] virt_owner [VirtFrames];
  logic [9:0]  virt_page [VirtFrames];
  int unsigned main_free;
  int unsigned virt_free;
  logic [15:0] next_pid;
  logic [3:0]  page_log2;
  rsp_t        expected_rsp [$];

  function automatic rsp_t allocate_step(req_t r);
    rsp_t res;
    int unsigned pages;
    int unsigned taken;
    int unsigned nm;
    int unsigned nv;
    res = '0;
    res.status = ST_BAD;
    case (action_t'(r.action))
      ACT_LOAD: begin
        pages = (32'(r.size_kb) << 10) >> page_log2;
        taken = 0;
        if (next_pid == 16'd0) begin
          res.status = ST_FULL;
        end else if (main_free >= pages) begin
          for (int f = 0; f < MainFrames && taken < pages; f++) begin
            if (main_owner[f] == 16'd0) begin
              main_owner[f] = next_pid;
              main_page[f] = taken[9:0];
              taken++;
            end
          end
          main_free -= pages;
          res.status = ST_MAIN;
          res.assigned_id = next_pid;
          next_pid = next_pid + 16'd1;
        end else if (virt_free >= pages) begin
          for (int f = 0; f < VirtFrames && taken < pages; f++) begin
            if (virt_owner[f] == 16'd0) begin
              virt_owner[f] = next_pid;
              virt_page[f] = taken[9:0];
              taken++;
            end
          end
          virt_free -= pages;
          res.status = ST_VIRT;
          res.assigned_id = next_pid;
          next_pid = next_pid + 16'd1;
        end else begin
          res.status = ST_FULL;
        end
      end
      ACT_KILL: begin
        nm = 0;
        nv = 0;
        if (r.process_id != 16'd0) begin
          for (int f = 0; f < MainFrames; f++) begin
            if (main_owner[f] == r.process_id) begin
              main_owner[f] = '0;
              main_page[f] = '0;
              nm++;
            end
          end
          for (int f = 0; f < VirtFrames; f++) begin
            if (virt_owner[f] == r.process_id) begin
              virt_owner[f] = '0;
              virt_page[f] = '0;
              nv++;
            end
          end
          main_free += nm;
          virt_free += nv;
          if (nm != 0) res.status = ST_MAIN;
          else if (nv != 0) res.status = ST_VIRT;
        end
      end
      ACT_XLATE: begin
        if (r.process_id != 16'd0) begin
          for (int f = MainFrames - 1; f >= 0; f--) begin
            if (main_owner[f] == r.process_id && main_page[f] == r.page_number) begin
              res.status = ST_MAIN;
              res.frame = FW'(f);
            end
          end
          if (res.status == ST_BAD) begin
            for (int f = VirtFrames - 1; f >= 0; f--) begin
              if (virt_owner[f] == r.process_id && virt_page[f] == r.page_number) begin
                res.status = ST_VIRT;
                res.frame = FW'(f);
              end
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      for (int f = 0; f < MainFrames; f++) begin
        main_owner[f] = '0;
        main_page[f] = '0;
      end
      for (int f = 0; f < VirtFrames; f++) begin
        virt_owner[f] = '0;
        virt_page[f] = '0;
      end
      main_free = MainFrames;
      virt_free = VirtFrames;
      next_pid = 16'd1;
      page_log2 = '0;
      expected_rsp.delete();
    end else begin
      if (cfg_we) page_log2 = cfg_wdata;
      if (req.valid && req.ready) expected_rsp = {expected_rsp, allocate_step(req.data)};
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", rsp.data);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.data.status !== want.status || rsp.data.assigned_id !== want.assigned_id
              || rsp.data.frame !== want.frame) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected status %0d id %0d frame %0d, got %0d %0d %0d",
                       want.status, want.assigned_id, want.frame, rsp.data.status,
                       rsp.data.assigned_id, rsp.data.frame);
          end
        end
      end
    end
    awaiting = expected_rsp.size();
  end

  initial mismatches = 0;
  initial awaiting = 0;
endmodule

// ----- test/two_tier_page_frame_allocator_tb.sv -----
// Stimulus and verdict for the two-tier page frame allocator.
`timescale 1ns / 1ps
module two_tier_page_frame_allocator_tb
  import tpfa_pkg::*;
();

  localparam int CycleLimit = 3_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;
  int snd_idle = 0;
  int rcv_idle = 0;
  int mismatches;
  int awaiting;
  int cycles = 0;
  int hold_cnt = 0;
  logic hold_go = 1'b0;

  tpfa_req_if in_req ();
  tpfa_rsp_if out_rsp ();

  two_tier_page_frame_allocator u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_req(in_req.sink), .out_rsp(out_rsp.source)
  );

  tpfa_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(in_req), .rsp(out_rsp), .mismatches(mismatches), .awaiting(awaiting)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL two_tier_page_frame_allocator");
      $finish;
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering requests.
  always @(posedge clk) begin
    if (hold_go) hold_cnt <= 400;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  always @(posedge clk) begin
    out_rsp.ready <= (hold_cnt == 0) && !hold_go && ($urandom_range(99) >= rcv_idle);
  end

  initial begin
    in_req.valid = 1'b0;
    in_req.data = '0;
    out_rsp.ready = 1'b0;
  end

  task automatic send_request(action_t act, int unsigned size_kb, int unsigned pid,
                              int unsigned pg);
    req_t r;
    r.action = act;
    r.size_kb = size_kb[10:0];
    r.process_id = pid[15:0];
    r.page_number = pg[9:0];
    in_req.valid <= 1'b1;
    in_req.data <= r;
    do @(posedge clk); while (!in_req.ready);
    if ($urandom_range(99) < snd_idle) begin
      in_req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_page_log2(logic [3:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request(int unsigned max_kb);
    int unsigned roll;
    int unsigned pid;
    int unsigned pg;
    int unsigned kb;
    roll = $urandom_range(99);
    pid = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(40);
    pg = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(63);
    kb = ($urandom_range(19) == 0) ? $urandom_range(2047) : $urandom_range(1, max_kb);
    if (roll < 42) send_request(ACT_LOAD, kb, pid, pg);
    else if (roll < 67) send_request(ACT_KILL, kb, pid, pg);
    else if (roll < 96) send_request(ACT_XLATE, kb, pid, pg);
    else send_request(ACT_NONE, kb, pid, pg);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    set_page_log2(4'd0);

    // With one-byte pages each KB is a full pool of 1024 frames.
    send_request(ACT_LOAD, 1, 0, 0);
    send_request(ACT_LOAD, 1, 0, 0);
    send_request(ACT_LOAD, 1, 0, 0);
    send_request(ACT_XLATE, 0, 1, 1023);
    send_request(ACT_XLATE, 0, 2, 0);
    send_request(ACT_XLATE, 0, 2, 1023);
    send_request(ACT_XLATE, 0, 0, 0);
    send_request(ACT_XLATE, 0, 3, 5);
    send_request(ACT_KILL, 0, 1, 0);
    send_request(ACT_KILL, 0, 2, 0);
    send_request(ACT_KILL, 0, 0, 0);
    send_request(ACT_KILL, 0, 65535, 0);
    send_request(ACT_NONE, 2047, 65535, 1023);
    send_request(ACT_LOAD, 2047, 0, 0);
    send_request(ACT_LOAD, 0, 0, 0);
    send_request(ACT_KILL, 0, 3, 0);
    send_request(ACT_XLATE, 0, 3, 0);
    drain();

    set_page_log2(4'd10);
    send_request(ACT_LOAD, 1024, 0, 0);
    send_request(ACT_LOAD, 1, 0, 0);
    send_request(ACT_XLATE, 0, 5, 0);
    send_request(ACT_KILL, 0, 4, 0);
    drain();

    snd_idle = 27;
    rcv_idle = 67;
    repeat (100) random_request(64);
    drain();

    set_page_log2(4'd5);
    snd_idle = 67;
    rcv_idle = 27;
    repeat (90) random_request(8);
    drain();

    set_page_log2(4'd8);
    snd_idle = 0;
    rcv_idle = 0;
    repeat (60) random_request(32);
    // Hold off the results so the block fills and stops taking requests.
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    repeat (20) send_request(ACT_XLATE, 0, $urandom_range(1, 40), $urandom_range(3));
    drain();

    send_request(ACT_LOAD, 1, 0, 0);
    send_request(ACT_KILL, 0, 65535, 0);
    send_request(ACT_XLATE, 0, 65535, 0);
    in_req.valid <= 1'b0;

    while (awaiting != 0) @(posedge clk);
    repeat (2100) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("PASS two_tier_page_frame_allocator");
    end else begin
      $display("FAIL two_tier_page_frame_allocator");
    end
    $finish;
  end
endmodule
